// ===== rtl/mono_framebuffer_draw_engine_defines.svh =====
// Assertion macros shared by the draw engine RTL.
// The enclosing module must provide clk and rst.
`ifndef MONO_FRAMEBUFFER_DRAW_ENGINE_DEFINES_SVH
`define MONO_FRAMEBUFFER_DRAW_ENGINE_DEFINES_SVH

// Condition in the same cycle.
`define MFDE_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Condition in the following cycle.
`define MFDE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/mfde_pkg.sv =====
`default_nettype none

package mfde_pkg;

  // Default geometry.
  localparam int COLUMNS_DEF    = 84;
  localparam int BANK_COUNT_DEF = 6;
  localparam int ROWS_DEF       = 48;

  // Glyph layout and coordinate width.
  localparam int GLYPH_FIRST = 32;
  localparam int GLYPH_COLS  = 5;
  localparam int GLYPH_COUNT = 96;
  localparam int CW          = 12;

  // Command codes.
  localparam logic [3:0] FN_SET       = 4'd0;
  localparam logic [3:0] FN_CLEAR     = 4'd1;
  localparam logic [3:0] FN_GET       = 4'd2;
  localparam logic [3:0] FN_LINE      = 4'd3;
  localparam logic [3:0] FN_CIRCLE    = 4'd4;
  localparam logic [3:0] FN_RECT      = 4'd5;
  localparam logic [3:0] FN_CHAR      = 4'd6;
  localparam logic [3:0] FN_READ_BYTE = 4'd7;
  localparam logic [3:0] FN_CLEAR_ALL = 4'd8;

  // Line kinds and fill styles.
  localparam logic [1:0] LK_WHITE     = 2'd0;
  localparam logic [1:0] LK_BLACK     = 2'd1;
  localparam logic [1:0] LK_DOTTED    = 2'd2;
  localparam logic [1:0] FILL_OUTLINE = 2'd0;
  localparam logic [1:0] FILL_BLACK   = 2'd1;

  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE, ST_DISPATCH, ST_PIX_RD, ST_PIX_WR, ST_GET_WAIT,
    ST_BYTE_WAIT, ST_CHAR, ST_LINE_INIT, ST_LINE_STEP, ST_LINE_DIV,
    ST_LINE_PUT, ST_LINE_NEXT, ST_CIRC_TEST, ST_CIRC_ITEM, ST_CIRC_NEXT,
    ST_CIRC_UPD, ST_RECT_ITEM, ST_RECT_NEXT, ST_FINISH
  } mfde_state_t;

  // Font: one entry per glyph, column 0 in the top byte.
  localparam logic [39:0] FONT_ROM [0:GLYPH_COUNT-1] = '{
    40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14,
    40'h242A7F2A12, 40'h2313086462, 40'h3649552250, 40'h0005030000,
    40'h001C224100, 40'h0041221C00, 40'h082A1C2A08, 40'h08083E0808,
    40'h0050300000, 40'h0808080808, 40'h0060600000, 40'h2010080402,
    40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
    40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503,
    40'h3649494936, 40'h064949291E, 40'h0036360000, 40'h0056360000,
    40'h0008142241, 40'h1414141414, 40'h4122140800, 40'h0201510906,
    40'h324979413E, 40'h7E1111117E, 40'h7F49494936, 40'h3E41414122,
    40'h7F4141221C, 40'h7F49494941, 40'h7F09090101, 40'h3E41415132,
    40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241,
    40'h7F40404040, 40'h7F0204027F, 40'h7F0408107F, 40'h3E4141413E,
    40'h7F09090906, 40'h3E4151215E, 40'h7F09192946, 40'h4649494931,
    40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F, 40'h7F2018207F,
    40'h6314081463, 40'h0304780403, 40'h6151494543, 40'h00007F4141,
    40'h0204081020, 40'h41417F0000, 40'h0402010204, 40'h4040404040,
    40'h0001020400, 40'h2054545478, 40'h7F48444438, 40'h3844444420,
    40'h384444487F, 40'h3854545418, 40'h087E090102, 40'h081454543C,
    40'h7F08040478, 40'h00447D4000, 40'h2040443D00, 40'h007F102844,
    40'h00417F4000, 40'h7C04180478, 40'h7C08040478, 40'h3844444438,
    40'h7C14141408, 40'h081414187C, 40'h7C08040408, 40'h4854545420,
    40'h043F444020, 40'h3C4040207C, 40'h1C2040201C, 40'h3C4030403C,
    40'h4428102844, 40'h0C5050503C, 40'h4464544C44, 40'h0008364100,
    40'h00007F0000, 40'h0041360800, 40'h08082A1C08, 40'h081C2A0808
  };

endpackage

`default_nettype wire

// ===== rtl/mfde_ram.sv =====
`default_nettype none

module mfde_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 504
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  // One write port, one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/mono_framebuffer_draw_engine.sv =====
`default_nettype none
`include "mono_framebuffer_draw_engine_defines.svh"

// Channel   Handshake               Payload
// command   start, busy             func, x_first, y_first, x_second, y_second,
//                                   radius, rect_width, rect_height, style, char_code
// result    done (one-cycle pulse)  read_value, rejected
//
// A command transaction is taken when start is high and busy is low; one result follows.
// Set, clear and get pixel read the addressed byte before their result; set and clear
// write it back when the pixel is on the buffer. Each line step runs the 24-step
// shift-subtract divider, then a pixel read, and a write when the pixel is on the buffer.
// After reset, and for clear all, a sweep writes every byte.
// The receiver cannot stall results; busy stays high until the result cycle ends.

module mono_framebuffer_draw_engine #(
  parameter int COLUMNS    = mfde_pkg::COLUMNS_DEF,
  parameter int BANK_COUNT = mfde_pkg::BANK_COUNT_DEF,
  parameter int ROWS       = mfde_pkg::ROWS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [3:0]        func,
  input  wire logic signed [9:0] x_first,
  input  wire logic signed [9:0] y_first,
  input  wire logic signed [9:0] x_second,
  input  wire logic signed [9:0] y_second,
  input  wire logic [7:0]        radius,
  input  wire logic [7:0]        rect_width,
  input  wire logic [7:0]        rect_height,
  input  wire logic [1:0]        style,
  input  wire logic [7:0]        char_code,
  output logic                   done,
  output logic [7:0]             read_value,
  output logic                   rejected
);
  import mfde_pkg::*;

  localparam int DEPTH = COLUMNS * BANK_COUNT;
  localparam int AW    = $clog2(DEPTH);
  localparam int NW    = 2 * CW;
  localparam int DCW   = $clog2(NW);

  typedef logic signed [CW-1:0] coord_t;

  mfde_state_t state, state_next;

  // Command registers.
  logic [3:0]  c_func;
  coord_t      xa_e, ya_e, xb_e, yb_e;
  logic [7:0]  c_rad, c_w, c_h, c_code;
  logic [1:0]  c_style;
  logic        clr_cmd;
  logic [AW-1:0] clr_addr;

  // Pixel, line, circle, rectangle and character working registers.
  coord_t      px, py;
  logic        pblack;
  mfde_state_t pix_ret, line_ret;
  coord_t      lx0, ly0, lx1, ly1;
  logic [1:0]  lkind;
  coord_t      l_maj0, l_min0, l_majd, l_mind, l_a, l_hi;
  logic        l_majx, l_neg;
  logic [CW-1:0] l_den, div_rem;
  logic [NW-1:0] div_num;
  logic [DCW-1:0] div_cnt;
  coord_t      ce_x, ce_y, ce_err, r_row;
  logic [2:0]  idx;
  logic [7:0]  res_value;
  logic        res_rej;

  // Memory port.
  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [7:0]    mem_wdata, mem_rdata;

  function automatic logic on_scr(input coord_t x, input coord_t y);
    return x >= 0 && x < $signed(CW'(COLUMNS)) && y >= 0 && y < $signed(CW'(ROWS))
           && (y >>> 3) < $signed(CW'(BANK_COUNT));
  endfunction

  function automatic logic [AW-1:0] addr_of(input coord_t col, input coord_t bank);
    return AW'(col[CW-2:0] * BANK_COUNT + bank[CW-2:0]);
  endfunction

  function automatic logic [CW-1:0] mag(input coord_t v);
    return v[CW-1] ? CW'(-v) : CW'(v);
  endfunction

  // Derived command values.
  coord_t rx1, ry1;
  logic   char_bad, byte_bad, get_ok, pix_on;
  logic [1:0] fill_kind;
  assign rx1       = xa_e + $signed(CW'(c_w));
  assign ry1       = ya_e + $signed(CW'(c_h));
  assign fill_kind = (c_style == FILL_BLACK) ? LK_BLACK : LK_WHITE;
  assign char_bad  = c_code < 8'(GLYPH_FIRST) || c_code[7] || ya_e < 0
                     || ya_e >= $signed(CW'(BANK_COUNT));
  assign byte_bad  = xa_e < 0 || xa_e >= $signed(CW'(COLUMNS)) || ya_e < 0
                     || ya_e >= $signed(CW'(BANK_COUNT));
  assign get_ok    = on_scr(xa_e, ya_e);
  assign pix_on    = on_scr(px, py);

  // Line setup.
  coord_t ln_dx, ln_dy, l_off, l_q, l_minor;
  logic   ln_zero, ln_majx, div_ge;
  logic [CW:0] div_trial;
  logic [NW-1:0] l_prod;
  assign ln_dx     = lx1 - lx0;
  assign ln_dy     = ly1 - ly0;
  assign ln_zero   = ln_dx == 0 && ln_dy == 0;
  assign ln_majx   = mag(ln_dx) > mag(ln_dy);
  assign l_off     = l_a - l_maj0;
  assign l_prod    = mag(l_mind) * mag(l_off);
  assign div_trial = {div_rem, div_num[NW-1]};
  assign div_ge    = div_trial >= {1'b0, l_den};
  assign l_q       = l_neg ? -$signed(div_num[CW-1:0]) : $signed(div_num[CW-1:0]);
  assign l_minor   = l_min0 + l_q;

  // Circle points; fill line i spans outline points {0,2,5,6}[i] to {1,3,4,7}[i].
  coord_t cpx, cpy, cl_x0, cl_x1, cl_y, cyn, cxn;
  logic   c_outline;
  logic [2:0] c_last;
  assign c_outline = c_style == FILL_OUTLINE;
  assign c_last    = c_outline ? 3'd7 : 3'd3;
  assign cyn       = ce_y + 1;
  assign cxn       = ce_x - 1;
  always_comb begin
    unique case (idx)
      3'd0: begin cpx = xa_e + ce_x; cpy = ya_e + ce_y; end
      3'd1: begin cpx = xa_e - ce_x; cpy = ya_e + ce_y; end
      3'd2: begin cpx = xa_e + ce_y; cpy = ya_e + ce_x; end
      3'd3: begin cpx = xa_e - ce_y; cpy = ya_e + ce_x; end
      3'd4: begin cpx = xa_e - ce_y; cpy = ya_e - ce_x; end
      3'd5: begin cpx = xa_e + ce_y; cpy = ya_e - ce_x; end
      3'd6: begin cpx = xa_e + ce_x; cpy = ya_e - ce_y; end
      default: begin cpx = xa_e - ce_x; cpy = ya_e - ce_y; end
    endcase
    unique case (idx[1:0])
      2'd0: begin cl_x0 = xa_e + ce_x; cl_x1 = xa_e - ce_x; cl_y = ya_e + ce_y; end
      2'd1: begin cl_x0 = xa_e + ce_y; cl_x1 = xa_e - ce_y; cl_y = ya_e + ce_x; end
      2'd2: begin cl_x0 = xa_e + ce_y; cl_x1 = xa_e - ce_y; cl_y = ya_e - ce_x; end
      default: begin cl_x0 = xa_e + ce_x; cl_x1 = xa_e - ce_x; cl_y = ya_e - ce_y; end
    endcase
  end

  // Character column and glyph byte.
  coord_t     ch_col;
  logic       ch_end, ch_wr;
  logic [6:0] glyph_idx;
  logic [39:0] glyph;
  logic [7:0] glyph_byte;
  assign ch_col     = xa_e + $signed(CW'(idx));
  assign ch_end     = ch_col > $signed(CW'(COLUMNS - 1));
  assign ch_wr      = !ch_end && ch_col >= 0;
  assign glyph_idx  = c_code[6:0] - 7'(GLYPH_FIRST);
  assign glyph      = FONT_ROM[glyph_idx];
  assign glyph_byte = glyph[(GLYPH_COLS - 1 - int'(idx)) * 8 +: 8];

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      clr_cmd  <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_addr <= (clr_addr == AW'(DEPTH - 1)) ? '0 : clr_addr + 1'b1;
      end
      if (state == ST_IDLE && start) begin
        clr_cmd <= func == FN_CLEAR_ALL;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          c_func  <= func;
          xa_e    <= CW'(x_first);
          ya_e    <= CW'(y_first);
          xb_e    <= CW'(x_second);
          yb_e    <= CW'(y_second);
          c_rad   <= radius;
          c_w     <= rect_width;
          c_h     <= rect_height;
          c_style <= style;
          c_code  <= char_code;
        end
      end
      ST_DISPATCH: begin
        res_value <= '0;
        res_rej   <= 1'b0;
        idx       <= '0;
        px        <= xa_e;
        py        <= ya_e;
        pblack    <= c_func == FN_SET;
        pix_ret   <= ST_FINISH;
        lx0       <= xa_e;
        ly0       <= ya_e;
        lx1       <= xb_e;
        ly1       <= yb_e;
        lkind     <= c_style;
        line_ret  <= ST_FINISH;
        ce_x      <= $signed(CW'(c_rad));
        ce_y      <= '0;
        ce_err    <= $signed(CW'(1)) - $signed(CW'(c_rad));
        r_row     <= ya_e;
        if (c_func == FN_CHAR) begin
          res_rej <= char_bad;
        end else if (c_func == FN_READ_BYTE) begin
          res_rej <= byte_bad;
        end
      end
      ST_GET_WAIT:  res_value <= {7'd0, mem_rdata[py[2:0]]};
      ST_BYTE_WAIT: res_value <= mem_rdata;
      ST_CHAR:      idx <= idx + 1'b1;
      ST_LINE_INIT: begin
        l_majx <= ln_majx;
        l_maj0 <= ln_majx ? lx0 : ly0;
        l_min0 <= ln_majx ? ly0 : lx0;
        l_majd <= ln_majx ? ln_dx : ln_dy;
        l_mind <= ln_majx ? ln_dy : ln_dx;
        l_den  <= ln_majx ? mag(ln_dx) : mag(ln_dy);
        if (ln_majx) begin
          l_a  <= (lx1 > lx0) ? lx0 : lx1;
          l_hi <= (lx1 > lx0) ? lx1 : lx0;
        end else begin
          l_a  <= (ly1 > ly0) ? ly0 : ly1;
          l_hi <= (ly1 > ly0) ? ly1 : ly0;
        end
        px      <= lx0;
        py      <= ly0;
        pblack  <= lkind != LK_WHITE;
        pix_ret <= line_ret;
      end
      ST_LINE_STEP: begin
        div_num <= l_prod;
        l_neg   <= l_mind[CW-1] ^ l_off[CW-1] ^ l_majd[CW-1];
        div_rem <= '0;
        div_cnt <= '0;
      end
      ST_LINE_DIV: begin
        div_rem <= div_ge ? CW'(div_trial - {1'b0, l_den}) : CW'(div_trial);
        div_num <= {div_num[NW-2:0], div_ge};
        div_cnt <= div_cnt + 1'b1;
      end
      ST_LINE_PUT: begin
        px      <= l_majx ? l_a : l_minor;
        py      <= l_majx ? l_minor : l_a;
        pblack  <= lkind != LK_WHITE;
        pix_ret <= ST_LINE_NEXT;
      end
      ST_LINE_NEXT: l_a <= l_a + ((lkind == LK_DOTTED) ? $signed(CW'(2)) : $signed(CW'(1)));
      ST_CIRC_ITEM: begin
        px       <= cpx;
        py       <= cpy;
        pblack   <= 1'b1;
        pix_ret  <= ST_CIRC_NEXT;
        lx0      <= cl_x0;
        lx1      <= cl_x1;
        ly0      <= cl_y;
        ly1      <= cl_y;
        lkind    <= fill_kind;
        line_ret <= ST_CIRC_NEXT;
      end
      ST_CIRC_NEXT: idx <= (idx == c_last) ? 3'd0 : idx + 1'b1;
      ST_CIRC_UPD: begin
        ce_y <= cyn;
        if (ce_err[CW-1]) begin
          ce_err <= ce_err + (cyn <<< 1) + $signed(CW'(1));
        end else begin
          ce_x   <= cxn;
          ce_err <= ce_err + ((cyn - cxn) <<< 1) + $signed(CW'(1));
        end
      end
      ST_RECT_ITEM: begin
        line_ret <= ST_RECT_NEXT;
        if (c_style == FILL_OUTLINE) begin
          lkind <= LK_BLACK;
          unique case (idx[1:0])
            2'd0: begin lx0 <= xa_e; ly0 <= ya_e; lx1 <= rx1; ly1 <= ya_e; end
            2'd1: begin lx0 <= xa_e; ly0 <= ry1; lx1 <= rx1; ly1 <= ry1; end
            2'd2: begin lx0 <= xa_e; ly0 <= ya_e; lx1 <= xa_e; ly1 <= ry1; end
            default: begin lx0 <= rx1; ly0 <= ya_e; lx1 <= rx1; ly1 <= ry1; end
          endcase
        end else begin
          lkind <= fill_kind;
          lx0   <= xa_e;
          lx1   <= rx1;
          ly0   <= r_row;
          ly1   <= r_row;
        end
      end
      ST_RECT_NEXT: begin
        idx   <= idx + 1'b1;
        r_row <= r_row + $signed(CW'(1));
      end
      default: begin
      end
    endcase
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (clr_addr == AW'(DEPTH - 1)) begin
          state_next = clr_cmd ? ST_FINISH : ST_IDLE;
        end
      end
      ST_IDLE: if (start) state_next = ST_DISPATCH;
      ST_DISPATCH: begin
        priority case (c_func)
          FN_SET, FN_CLEAR: state_next = ST_PIX_RD;
          FN_GET:       state_next = get_ok ? ST_GET_WAIT : ST_FINISH;
          FN_LINE:      state_next = ST_LINE_INIT;
          FN_CIRCLE:    state_next = ST_CIRC_TEST;
          FN_RECT:      state_next = ST_RECT_ITEM;
          FN_CHAR:      state_next = char_bad ? ST_FINISH : ST_CHAR;
          FN_READ_BYTE: state_next = byte_bad ? ST_FINISH : ST_BYTE_WAIT;
          FN_CLEAR_ALL: state_next = ST_CLEAR;
          default:      state_next = ST_FINISH;
        endcase
      end
      ST_PIX_RD:    state_next = pix_on ? ST_PIX_WR : pix_ret;
      ST_PIX_WR:    state_next = pix_ret;
      ST_GET_WAIT:  state_next = ST_FINISH;
      ST_BYTE_WAIT: state_next = ST_FINISH;
      ST_CHAR: begin
        if (ch_end || idx == 3'(GLYPH_COLS - 1)) state_next = ST_FINISH;
      end
      ST_LINE_INIT: state_next = ln_zero ? ST_PIX_RD : ST_LINE_STEP;
      ST_LINE_STEP: state_next = (l_a > l_hi) ? line_ret : ST_LINE_DIV;
      ST_LINE_DIV:  if (div_cnt == DCW'(NW - 1)) state_next = ST_LINE_PUT;
      ST_LINE_PUT:  state_next = ST_PIX_RD;
      ST_LINE_NEXT: state_next = ST_LINE_STEP;
      ST_CIRC_TEST: state_next = (ce_x >= ce_y) ? ST_CIRC_ITEM : ST_FINISH;
      ST_CIRC_ITEM: state_next = c_outline ? ST_PIX_RD : ST_LINE_INIT;
      ST_CIRC_NEXT: state_next = (idx == c_last) ? ST_CIRC_UPD : ST_CIRC_ITEM;
      ST_CIRC_UPD:  state_next = ST_CIRC_TEST;
      ST_RECT_ITEM: begin
        if (c_style != FILL_OUTLINE && r_row > ry1) begin
          state_next = ST_FINISH;
        end else begin
          state_next = ST_LINE_INIT;
        end
      end
      ST_RECT_NEXT: begin
        if (c_style == FILL_OUTLINE && idx == 3'd3) begin
          state_next = ST_FINISH;
        end else begin
          state_next = ST_RECT_ITEM;
        end
      end
      ST_FINISH: state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // Outputs and memory control.
  always_comb begin
    busy      = state != ST_IDLE;
    done      = state == ST_FINISH;
    mem_we    = 1'b0;
    mem_waddr = addr_of(px, py >>> 3);
    mem_wdata = pblack ? (mem_rdata | (8'd1 << py[2:0]))
                       : (mem_rdata & ~(8'd1 << py[2:0]));
    mem_raddr = addr_of(px, py >>> 3);
    unique case (state)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
        mem_wdata = '0;
      end
      ST_DISPATCH: begin
        mem_raddr = (c_func == FN_READ_BYTE) ? addr_of(xa_e, ya_e)
                                             : addr_of(xa_e, ya_e >>> 3);
      end
      ST_PIX_WR: mem_we = 1'b1;
      ST_CHAR: begin
        mem_we    = ch_wr;
        mem_waddr = addr_of(ch_col, ya_e);
        mem_wdata = glyph_byte;
      end
      default: begin
      end
    endcase
  end

  assign read_value = res_value;
  assign rejected   = res_rej;

  mfde_ram #(
    .WIDTH(8),
    .DEPTH(DEPTH)
  ) u_frame_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  // Only character and read-byte commands may refuse a transaction.
  logic rej_cmd, waddr_ok;
  assign rej_cmd  = c_func == FN_CHAR || c_func == FN_READ_BYTE;
  assign waddr_ok = mem_waddr <= AW'(DEPTH - 1);

  // Checks on the sequencer and the frame memory.
  `MFDE_ASSERT_IMPL(a_idle_no_write, !busy, !mem_we, "frame write while idle")
  `MFDE_ASSERT_IMPL(a_waddr_range, mem_we, waddr_ok, "write address out of range")
  `MFDE_ASSERT_IMPL(a_reject_source, done && rejected, rej_cmd, "reject from wrong command")
  `MFDE_ASSERT_NEXT(a_rmw_write, state == ST_PIX_RD && pix_on, state == ST_PIX_WR && mem_we, "pixel read not followed by write")

endmodule

`default_nettype wire

// ===== tb/tb_mono_framebuffer_draw_engine.sv =====
`timescale 1ns / 100ps
`default_nettype none

module tb_mono_framebuffer_draw_engine;
  import mfde_pkg::*;

  localparam int NCOLS     = 84;
  localparam int NBANKS    = 6;
  localparam int NROWS     = 48;
  localparam int IDLE_LIMIT = 500000;
  localparam int RANDOM_ITEMS = 1140;
  localparam logic [1:0] STYLE_THREE = 2'd3;

  typedef struct {
    logic [3:0]        fn;
    logic signed [9:0] xa;
    logic signed [9:0] ya;
    logic signed [9:0] xb;
    logic signed [9:0] yb;
    logic [7:0]        rad;
    logic [7:0]        wid;
    logic [7:0]        hgt;
    logic [1:0]        sty;
    logic [7:0]        code;
  } draw_cmd_t;

  typedef struct {
    logic [7:0] value;
    logic       rej;
  } draw_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [3:0] func = '0;
  logic signed [9:0] x_first = '0, y_first = '0, x_second = '0, y_second = '0;
  logic [7:0] radius = '0, rect_width = '0, rect_height = '0, char_code = '0;
  logic [1:0] style = '0;
  logic busy, done, rejected;
  logic [7:0] read_value;

  // Shadow copy of the frame store and the queue of pending results.
  logic [7:0] shadow_fb [0:NCOLS*NBANKS-1];
  draw_result_t pending_results[$];
  int error_count = 0;
  int idle_cycles = 0;

  mono_framebuffer_draw_engine uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .func(func),
    .x_first(x_first), .y_first(y_first), .x_second(x_second), .y_second(y_second),
    .radius(radius), .rect_width(rect_width), .rect_height(rect_height),
    .style(style), .char_code(char_code), .done(done), .read_value(read_value),
    .rejected(rejected)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Pixel helpers on the shadow frame store.
  function automatic bit visible(int x, int y);
    return x >= 0 && x < NCOLS && y >= 0 && y < NROWS;
  endfunction

  function automatic void paint(int x, int y, bit black);
    int idx;
    if (!visible(x, y)) return;
    idx = x * NBANKS + y / 8;
    if (black) shadow_fb[idx][y % 8] = 1'b1;
    else shadow_fb[idx][y % 8] = 1'b0;
  endfunction

  // Interpolated line; the minor axis uses a quotient truncated toward zero.
  function automatic void trace_line(int x0, int y0, int x1, int y1, logic [1:0] kind);
    int dx, dy, stp, lo, hi;
    bit black;
    dx = x1 - x0;
    dy = y1 - y0;
    stp = (kind == LK_DOTTED) ? 2 : 1;
    black = (kind != LK_WHITE);
    if (dx == 0 && dy == 0) begin
      paint(x0, y0, black);
      return;
    end
    if ((dx < 0 ? -dx : dx) > (dy < 0 ? -dy : dy)) begin
      lo = (x1 > x0) ? x0 : x1;
      hi = (x1 > x0) ? x1 : x0;
      for (int a = lo; a <= hi; a += stp) paint(a, y0 + dy * (a - x0) / dx, black);
    end else begin
      lo = (y1 > y0) ? y0 : y1;
      hi = (y1 > y0) ? y1 : y0;
      for (int a = lo; a <= hi; a += stp) paint(x0 + dx * (a - y0) / dy, a, black);
    end
  endfunction

  // Midpoint circle, either as an outline or as horizontal spans.
  function automatic void trace_circle(int cx, int cy, int r, logic [1:0] fill);
    int x, y, err;
    logic [1:0] kind;
    x = r;
    y = 0;
    err = 1 - r;
    kind = (fill == FILL_BLACK) ? LK_BLACK : LK_WHITE;
    while (x >= y) begin
      if (fill == FILL_OUTLINE) begin
        paint(cx + x, cy + y, 1); paint(cx - x, cy + y, 1);
        paint(cx + y, cy + x, 1); paint(cx - y, cy + x, 1);
        paint(cx - y, cy - x, 1); paint(cx + y, cy - x, 1);
        paint(cx + x, cy - y, 1); paint(cx - x, cy - y, 1);
      end else begin
        trace_line(cx + x, cy + y, cx - x, cy + y, kind);
        trace_line(cx + y, cy + x, cx - y, cy + x, kind);
        trace_line(cx + y, cy - x, cx - y, cy - x, kind);
        trace_line(cx + x, cy - y, cx - x, cy - y, kind);
      end
      y++;
      if (err < 0) begin
        err += 2 * y + 1;
      end else begin
        x--;
        err += 2 * (y - x) + 1;
      end
    end
  endfunction

  // Applies one command to the shadow store and returns its result.
  function automatic draw_result_t predict_draw(draw_cmd_t c);
    draw_result_t res;
    int xa, ya, w, h;
    logic [39:0] glyph;
    xa = c.xa;
    ya = c.ya;
    w = c.wid;
    h = c.hgt;
    res.value = '0;
    res.rej = 1'b0;
    case (c.fn)
      FN_SET:   paint(xa, ya, 1);
      FN_CLEAR: paint(xa, ya, 0);
      FN_GET: begin
        if (visible(xa, ya)) res.value = {7'd0, shadow_fb[xa * NBANKS + ya / 8][ya % 8]};
      end
      FN_LINE:   trace_line(xa, ya, c.xb, c.yb, c.sty);
      FN_CIRCLE: trace_circle(xa, ya, c.rad, c.sty);
      FN_RECT: begin
        if (c.sty == FILL_OUTLINE) begin
          trace_line(xa, ya, xa + w, ya, LK_BLACK);
          trace_line(xa, ya + h, xa + w, ya + h, LK_BLACK);
          trace_line(xa, ya, xa, ya + h, LK_BLACK);
          trace_line(xa + w, ya, xa + w, ya + h, LK_BLACK);
        end else begin
          for (int y = ya; y <= ya + h; y++)
            trace_line(xa, y, xa + w, y, (c.sty == FILL_BLACK) ? LK_BLACK : LK_WHITE);
        end
      end
      FN_CHAR: begin
        if (c.code < GLYPH_FIRST || c.code > 127 || ya < 0 || ya >= NBANKS) begin
          res.rej = 1'b1;
        end else begin
          glyph = FONT_ROM[c.code - GLYPH_FIRST];
          for (int i = 0; i < GLYPH_COLS; i++) begin
            if (xa + i > NCOLS - 1) break;
            if (xa + i >= 0) shadow_fb[(xa + i) * NBANKS + ya] = glyph[39 - 8 * i -: 8];
          end
        end
      end
      FN_READ_BYTE: begin
        if (xa < 0 || xa >= NCOLS || ya < 0 || ya >= NBANKS) res.rej = 1'b1;
        else res.value = shadow_fb[xa * NBANKS + ya];
      end
      FN_CLEAR_ALL: begin
        foreach (shadow_fb[i]) shadow_fb[i] = '0;
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic draw_cmd_t make_cmd(logic [3:0] fn, int xa, int ya, int xb = 0,
                                         int yb = 0, int rad = 0, int wid = 0,
                                         int hgt = 0, logic [1:0] sty = 0, int code = 0);
    draw_cmd_t c;
    c.fn = fn; c.xa = 10'(xa); c.ya = 10'(ya); c.xb = 10'(xb); c.yb = 10'(yb);
    c.rad = 8'(rad); c.wid = 8'(wid); c.hgt = 8'(hgt); c.sty = sty; c.code = 8'(code);
    return c;
  endfunction

  // Sends one command transaction after a gap; start stays high if the next gap is zero.
  task automatic send_cmd(draw_cmd_t c, int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    func <= c.fn; x_first <= c.xa; y_first <= c.ya; x_second <= c.xb; y_second <= c.yb;
    radius <= c.rad; rect_width <= c.wid; rect_height <= c.hgt; style <= c.sty;
    char_code <= c.code;
    start <= 1'b1;
    forever begin
      @(negedge clk);
      if (!busy) break;
    end
    @(posedge clk);
    pending_results.push_back(predict_draw(c));
  endtask

  task automatic send_gapped(draw_cmd_t c);
    send_cmd(c, $urandom_range(0, 11));
  endtask

  // Lets every outstanding result arrive before continuing.
  task automatic drain_results();
    start <= 1'b0;
    forever begin
      @(negedge clk);
      if (pending_results.size() == 0) break;
    end
    @(posedge clk);
  endtask

  task automatic report_mismatch(string what, int got, int want);
    $display("ERROR at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    error_count++;
  endtask

  // Result checker: each done pulse is compared with the oldest expectation.
  always @(negedge clk) begin
    draw_result_t want;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result, pending count", 1, 0);
      end else begin
        want = pending_results.pop_front();
        if (read_value !== want.value) report_mismatch("read_value", read_value, want.value);
        if (rejected !== want.rej) report_mismatch("rejected", rejected, want.rej);
      end
    end
  end

  // Watchdog on cycles with no transaction in either direction.
  always @(negedge clk) begin
    if (rst || done || (start && !busy)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic test_pixels();
    send_gapped(make_cmd(FN_SET, 0, 0));
    send_gapped(make_cmd(FN_SET, 83, 47));
    send_gapped(make_cmd(FN_SET, -1, 5));
    send_gapped(make_cmd(FN_SET, 84, 48));
    send_gapped(make_cmd(FN_GET, 0, 0));
    send_gapped(make_cmd(FN_GET, 83, 47));
    send_gapped(make_cmd(FN_CLEAR, 0, 0));
    send_gapped(make_cmd(FN_GET, 0, 0));
    send_gapped(make_cmd(FN_GET, -512, 511));
  endtask

  task automatic test_lines();
    send_gapped(make_cmd(FN_LINE, 0, 0, 83, 47, 0, 0, 0, LK_BLACK));
    send_gapped(make_cmd(FN_LINE, 10, 10, 10, 10, 0, 0, 0, LK_BLACK));
    send_gapped(make_cmd(FN_LINE, 10, 10, 10, 10, 0, 0, 0, LK_WHITE));
    send_gapped(make_cmd(FN_LINE, -512, -512, 511, 20, 0, 0, 0, LK_DOTTED));
    send_gapped(make_cmd(FN_LINE, 5, 40, 20, 2, 0, 0, 0, STYLE_THREE));
    send_gapped(make_cmd(FN_LINE, 70, 30, 2, 35, 0, 0, 0, LK_WHITE));
  endtask

  task automatic test_shapes();
    send_gapped(make_cmd(FN_CIRCLE, 42, 24, 0, 0, 10, 0, 0, FILL_OUTLINE));
    send_gapped(make_cmd(FN_CIRCLE, 20, 20, 0, 0, 5, 0, 0, FILL_BLACK));
    send_gapped(make_cmd(FN_CIRCLE, 21, 20, 0, 0, 4, 0, 0, 2'd2));
    send_gapped(make_cmd(FN_CIRCLE, 0, 0, 0, 0, 200, 0, 0, FILL_OUTLINE));
    send_gapped(make_cmd(FN_CIRCLE, 60, 10, 0, 0, 3, 0, 0, STYLE_THREE));
    send_gapped(make_cmd(FN_CIRCLE, 30, 30, 0, 0, 0, 0, 0, FILL_BLACK));
    send_gapped(make_cmd(FN_RECT, -5, -5, 0, 0, 0, 255, 255, FILL_OUTLINE));
    send_gapped(make_cmd(FN_RECT, 10, 10, 0, 0, 0, 6, 4, FILL_BLACK));
    send_gapped(make_cmd(FN_RECT, 12, 11, 0, 0, 0, 2, 2, 2'd2));
    send_gapped(make_cmd(FN_RECT, 40, 40, 0, 0, 0, 3, 0, STYLE_THREE));
  endtask

  task automatic test_chars();
    send_gapped(make_cmd(FN_CHAR, 0, 0, 0, 0, 0, 0, 0, 0, 32));
    send_gapped(make_cmd(FN_CHAR, 5, 5, 0, 0, 0, 0, 0, 0, 127));
    send_gapped(make_cmd(FN_CHAR, 10, 1, 0, 0, 0, 0, 0, 0, 65));
    send_gapped(make_cmd(FN_CHAR, 10, 1, 0, 0, 0, 0, 0, 0, 31));
    send_gapped(make_cmd(FN_CHAR, 10, 1, 0, 0, 0, 0, 0, 0, 128));
    send_gapped(make_cmd(FN_CHAR, 10, 1, 0, 0, 0, 0, 0, 0, 255));
    send_gapped(make_cmd(FN_CHAR, 10, -1, 0, 0, 0, 0, 0, 0, 66));
    send_gapped(make_cmd(FN_CHAR, 10, 6, 0, 0, 0, 0, 0, 0, 66));
    send_gapped(make_cmd(FN_CHAR, 82, 2, 0, 0, 0, 0, 0, 0, 87));
    send_gapped(make_cmd(FN_CHAR, -3, 3, 0, 0, 0, 0, 0, 0, 87));
  endtask

  task automatic test_bytes();
    send_gapped(make_cmd(FN_READ_BYTE, 0, 0));
    send_gapped(make_cmd(FN_READ_BYTE, 83, 5));
    send_gapped(make_cmd(FN_READ_BYTE, 11, 1));
    send_gapped(make_cmd(FN_READ_BYTE, 84, 0));
    send_gapped(make_cmd(FN_READ_BYTE, 0, -1));
    send_gapped(make_cmd(4'd9, 3, 3));
    send_gapped(make_cmd(4'd15, 3, 3));
    send_gapped(make_cmd(FN_CLEAR_ALL, 0, 0));
    send_gapped(make_cmd(FN_READ_BYTE, 11, 1));
  endtask

  // Mostly near the buffer, sometimes anywhere in the field range.
  function automatic int pick_coord(int span);
    if ($urandom_range(0, 99) < 85) return $urandom_range(0, span + 15) - 8;
    return $urandom_range(0, 1023) - 512;
  endfunction

  function automatic int near(int base);
    int v;
    v = base + $urandom_range(0, 24) - 12;
    if (v > 511) v = 511;
    if (v < -512) v = -512;
    return v;
  endfunction

  task automatic test_random();
    draw_cmd_t c;
    int pick, gap;
    bit burst;
    burst = 0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 60 == 0) burst = $urandom_range(0, 3) == 0;
      c = make_cmd(FN_SET, pick_coord(NCOLS), pick_coord(NROWS));
      c.sty = 2'($urandom_range(0, 3));
      c.code = 8'($urandom_range(0, 255));
      c.xb = 10'($urandom_range(0, 1023));
      c.yb = 10'($urandom_range(0, 1023));
      pick = $urandom_range(0, 99);
      if (pick < 12) c.fn = FN_SET;
      else if (pick < 20) c.fn = FN_CLEAR;
      else if (pick < 34) c.fn = FN_GET;
      else if (pick < 48) begin
        c.fn = FN_LINE;
        c.xb = 10'(near(c.xa));
        c.yb = 10'(near(c.ya));
      end else if (pick < 56) begin
        c.fn = FN_CIRCLE;
        c.rad = (c.sty == FILL_OUTLINE && $urandom_range(0, 19) == 0) ?
                8'($urandom_range(0, 255)) : 8'($urandom_range(0, 5));
      end else if (pick < 64) begin
        c.fn = FN_RECT;
        if (c.sty == FILL_OUTLINE && $urandom_range(0, 24) == 0) begin
          c.wid = 8'($urandom_range(0, 255));
          c.hgt = 8'($urandom_range(0, 255));
        end else begin
          c.wid = 8'($urandom_range(0, 5));
          c.hgt = 8'($urandom_range(0, 5));
        end
      end else if (pick < 78) begin
        c.fn = FN_CHAR;
        c.xa = 10'($urandom_range(0, 95) - 6);
        c.ya = ($urandom_range(0, 9) == 0) ? 10'(pick_coord(NBANKS)) :
               10'($urandom_range(0, 5));
        if ($urandom_range(0, 4) != 0) c.code = 8'($urandom_range(32, 127));
      end else if (pick < 95) begin
        c.fn = FN_READ_BYTE;
        c.ya = ($urandom_range(0, 9) == 0) ? 10'(pick_coord(NBANKS)) :
               10'($urandom_range(0, 5));
      end else if (pick < 97) c.fn = 4'($urandom_range(9, 15));
      else c.fn = FN_CLEAR_ALL;
      gap = burst ? 0 : $urandom_range(0, 11);
      send_cmd(c, gap);
      if (n == RANDOM_ITEMS / 2) drain_results();
    end
  endtask

  initial begin
    foreach (shadow_fb[i]) shadow_fb[i] = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_pixels();
    test_lines();
    test_shapes();
    drain_results();
    test_chars();
    test_bytes();
    test_random();
    drain_results();
    repeat (100) @(posedge clk);
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

`default_nettype wire
